// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rebinner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// File: rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// Rebinner package
// Shared widths, request codes and types for the linear interpolation rebinner.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Q16.16 data width of energies, fluxes and results.
    localparam int DATA_W = 32;
    // Width of the unsigned product of two magnitudes.
    localparam int PROD_W = 2 * DATA_W;
    // Quotient bits produced by the divider; larger quotients are overflow.
    localparam int QUO_W = 34;

    // Request codes on the action field.
    localparam logic [1:0] ACT_CLEAR      = 2'd0;
    localparam logic [1:0] ACT_APPEND     = 2'd1;
    localparam logic [1:0] ACT_FIRST_EDGE = 2'd2;
    localparam logic [1:0] ACT_NEXT_EDGE  = 2'd3;

    // Signed 32-bit limits.
    localparam logic [DATA_W-1:0] INT32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] INT32_MIN = 32'h8000_0000;

    // Quotients above this are saturated directly to a signed 32-bit limit.
    localparam logic [QUO_W-1:0] QUO_LIMIT = 34'h2_0000_0000;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic done;
        logic overflow;
    } lir_div_status_t;

endpackage

// File: rtl/lir_table.sv
// ----------------------------------------------------------------------------
// Point table
// Energy and flux memories with one write port and one registered read port
// each.
// ----------------------------------------------------------------------------
module lir_table #(
    parameter int TABLE_DEPTH = 256,
    parameter int ADDR_W      = 8
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [lir_pkg::DATA_W-1:0] wr_energy,
    input  logic [lir_pkg::DATA_W-1:0] wr_flux,
    input  logic [ADDR_W-1:0]         e_rd_addr,
    input  logic [ADDR_W-1:0]         f_rd_addr,
    output logic [lir_pkg::DATA_W-1:0] e_rd_data,
    output logic [lir_pkg::DATA_W-1:0] f_rd_data
);
    import lir_pkg::*;

    logic [DATA_W-1:0] energy_mem [TABLE_DEPTH];
    logic [DATA_W-1:0] flux_mem   [TABLE_DEPTH];

    // Both memories are written together when a point is appended.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            energy_mem[wr_addr] <= wr_energy;
            flux_mem[wr_addr]   <= wr_flux;
        end
    end

    // Read data is registered and valid in the cycle after the address.
    always_ff @(posedge aclk) begin
        e_rd_data <= energy_mem[e_rd_addr];
        f_rd_data <= flux_mem[f_rd_addr];
    end

endmodule

// File: rtl/lir_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider, one quotient bit per cycle, for a 64-bit dividend and a
// nonzero 32-bit divisor; flags quotients too large for its quotient width.
// ----------------------------------------------------------------------------
module lir_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [lir_pkg::PROD_W-1:0]       dividend,
    input  logic [lir_pkg::DATA_W-1:0]       divisor,
    output logic [lir_pkg::QUO_W-1:0]        quotient,
    output lir_pkg::lir_div_status_t         status
);
    import lir_pkg::*;

    localparam int CNT_W  = $clog2(QUO_W);

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic                ovf_reg,   ovf_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [DATA_W-1:0]   rem_reg,   rem_next;
    logic [QUO_W-1:0]    shift_reg, shift_next;

    logic [DATA_W-1:0]   high_part;
    logic [DATA_W:0]     trial;
    logic                trial_ge;
    logic [DATA_W:0]     trial_sub;

    // The upper dividend bits seed the remainder; if they already reach the
    // divisor the quotient cannot fit.
    assign high_part = DATA_W'(dividend[PROD_W-1:QUO_W]);
    assign trial     = {rem_reg, shift_reg[QUO_W-1]};
    assign trial_ge  = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};

    // Sequencing of one division.
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        if (start) begin
            ovf_next   = high_part >= divisor;
            rem_next   = high_part;
            shift_next = dividend[QUO_W-1:0];
            cnt_next   = '0;
            if (high_part >= divisor) begin
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next   = trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            shift_next = {shift_reg[QUO_W-2:0], trial_ge};
            cnt_next   = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath state.
    always_ff @(posedge aclk) begin
        ovf_reg   <= ovf_next;
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
    end

    assign quotient        = shift_reg;
    assign status.done     = done_reg;
    assign status.overflow = ovf_reg;

endmodule

// File: rtl/linear_interp_rebinner.sv
// ----------------------------------------------------------------------------
// Linear interpolation rebinner
// Loads a table of (energy, flux) points, then turns a stream of bin edges
// into interpolated flux times bin width, in Q16.16 with saturation.
//
//   Channel   Direction  Ports
//   s_        in         s_valid, s_ready, s_action, s_energy_value,
//                        s_flux_value
//   m_        out        m_valid, m_ready, m_bin_value, m_outside_table,
//                        m_saturated
//
// Table requests and first edges are handled in the idle state. A next-edge
// request that closes a bin holds s_ready low while the sequencer steps
// through a search state and a compare state for each table point the
// search pointer reads, three read states for the bracketing points, two
// passes through the shared 32x32 multiplier, the divider, and the load of
// the output register. A bin outside the table ends earlier.
// A finished result waits in the output register, and new requests are taken
// meanwhile; a full output register stalls the next bin until m_ready.
// Reset is synchronous; the table memories are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module linear_interp_rebinner #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [lir_pkg::DATA_W-1:0] s_energy_value,
    input  logic [lir_pkg::DATA_W-1:0] s_flux_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [lir_pkg::DATA_W-1:0] m_bin_value,
    output logic                       m_outside_table,
    output logic                       m_saturated
);
    import lir_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_RDC  = 4'd5;
    localparam logic [3:0] S_MUL1 = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DIVW = 4'd8;
    localparam logic [3:0] S_MUL2 = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // Control state.
    logic [3:0]        state_reg,     state_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  sp_reg,        sp_next;
    logic [CNT_W-1:0]  j_reg,         j_next;
    logic              edge_seen_reg, edge_seen_next;
    logic              m_valid_reg,   m_valid_next;

    // Datapath state.
    logic [DATA_W-1:0] prev_edge_reg, prev_edge_next;
    logic [DATA_W-1:0] mid_reg,       mid_next;
    logic [DATA_W-1:0] width_mag_reg, width_mag_next;
    logic              width_neg_reg, width_neg_next;
    logic [DATA_W-1:0] e_hi_reg,      e_hi_next;
    logic [DATA_W-1:0] e_lo_reg,      e_lo_next;
    logic [DATA_W-1:0] f_hi_reg,      f_hi_next;
    logic [DATA_W-1:0] f_lo_reg,      f_lo_next;
    logic [DATA_W-1:0] mul_a_reg,     mul_a_next;
    logic [DATA_W-1:0] mul_b_reg,     mul_b_next;
    logic [PROD_W-1:0] prod_reg,      prod_next;
    logic [DATA_W-1:0] den_mag_reg,   den_mag_next;
    logic              quo_neg_reg,   quo_neg_next;
    logic              res_neg_reg,   res_neg_next;
    logic              sat_reg,       sat_next;
    logic              outside_reg,   outside_next;
    logic [DATA_W-1:0] m_bin_reg,     m_bin_next;
    logic              m_out_reg,     m_out_next;
    logic              m_sat_reg,     m_sat_next;

    // Table and divider connections.
    logic              s_fire;
    logic              tbl_wr_en;
    logic [ADDR_W-1:0] e_rd_addr;
    logic [ADDR_W-1:0] f_rd_addr;
    logic [DATA_W-1:0] e_rd_data;
    logic [DATA_W-1:0] f_rd_data;
    logic              div_start;
    logic [QUO_W-1:0]  div_quotient;
    lir_div_status_t   div_status;

    // Arithmetic helpers.
    logic [DATA_W:0]   edge_sum;
    logic [DATA_W:0]   width_diff;
    logic [DATA_W:0]   width_abs;
    logic [DATA_W:0]   den_diff;
    logic [DATA_W:0]   den_abs;
    logic [DATA_W:0]   dflux_diff;
    logic [DATA_W:0]   dflux_abs;
    logic [DATA_W:0]   num_diff;
    logic [DATA_W:0]   num_abs;
    logic [CNT_W-1:0]  lo_idx;
    logic [CNT_W-1:0]  sp_back;
    logic              quo_big;
    logic [QUO_W:0]    quo_ext;
    logic [QUO_W:0]    flo_ext;
    logic [QUO_W:0]    flux_sum;
    logic              flux_pos_clip;
    logic              flux_neg_clip;
    logic [DATA_W-1:0] flux_val;
    logic              flux_clip;
    logic [DATA_W:0]   flux_abs;
    logic [PROD_W-1:0] mul_full;
    logic [PROD_W-17:0] res_mag;
    logic [DATA_W-1:0] res_val;
    logic              res_clip;

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // Edge midpoint and signed bin width.
    assign edge_sum   = {1'b0, s_energy_value} + {1'b0, prev_edge_reg};
    assign width_diff = {1'b0, s_energy_value} - {1'b0, prev_edge_reg};
    assign width_abs  = width_diff[DATA_W] ? ((DATA_W+1)'(0) - width_diff) : width_diff;

    // Differences between the bracketing points.
    assign den_diff   = {1'b0, e_hi_reg} - {1'b0, e_lo_reg};
    assign den_abs    = den_diff[DATA_W] ? ((DATA_W+1)'(0) - den_diff) : den_diff;
    assign dflux_diff = {f_hi_reg[DATA_W-1], f_hi_reg} - {f_rd_data[DATA_W-1], f_rd_data};
    assign dflux_abs  = dflux_diff[DATA_W] ? ((DATA_W+1)'(0) - dflux_diff) : dflux_diff;
    assign num_diff   = {1'b0, mid_reg} - {1'b0, e_lo_reg};
    assign num_abs    = num_diff[DATA_W] ? ((DATA_W+1)'(0) - num_diff) : num_diff;

    assign lo_idx  = j_reg - CNT_W'(1);
    assign sp_back = (j_reg == '0) ? '0 : lo_idx;

    // Interpolated flux from the quotient, clipped to 32 bits.
    assign quo_big  = div_status.overflow || (div_quotient > QUO_LIMIT);
    assign quo_ext  = {1'b0, div_quotient};
    assign flo_ext  = {{(QUO_W + 1 - DATA_W){f_lo_reg[DATA_W-1]}}, f_lo_reg};
    assign flux_sum = quo_neg_reg ? (flo_ext - quo_ext) : (flo_ext + quo_ext);
    assign flux_pos_clip = !flux_sum[QUO_W] && (|flux_sum[QUO_W-1:DATA_W-1]);
    assign flux_neg_clip = flux_sum[QUO_W] && !(&flux_sum[QUO_W-1:DATA_W-1]);

    always_comb begin
        flux_clip = 1'b1;
        if (quo_big) begin
            flux_val = quo_neg_reg ? INT32_MIN : INT32_MAX;
        end else if (flux_pos_clip) begin
            flux_val = INT32_MAX;
        end else if (flux_neg_clip) begin
            flux_val = INT32_MIN;
        end else begin
            flux_val  = flux_sum[DATA_W-1:0];
            flux_clip = 1'b0;
        end
    end

    assign flux_abs = flux_val[DATA_W-1] ? ((DATA_W+1)'(0) - {1'b1, flux_val})
                                         : {1'b0, flux_val};

    // The shared multiplier; its product is always registered.
    assign mul_full = mul_a_reg * mul_b_reg;

    // Final scaling by 2^-16 with truncation toward zero, then clipping.
    assign res_mag = prod_reg[PROD_W-1:16];

    always_comb begin
        res_clip = 1'b0;
        if (!res_neg_reg) begin
            if (res_mag > (PROD_W-16)'(INT32_MAX)) begin
                res_val  = INT32_MAX;
                res_clip = 1'b1;
            end else begin
                res_val = res_mag[DATA_W-1:0];
            end
        end else begin
            if (res_mag > (PROD_W-16)'(INT32_MIN)) begin
                res_val  = INT32_MIN;
                res_clip = 1'b1;
            end else begin
                res_val = DATA_W'(0) - res_mag[DATA_W-1:0];
            end
        end
    end

    // Table read addresses for the search and for the bracketing points.
    always_comb begin
        e_rd_addr = '0;
        f_rd_addr = '0;
        unique case (state_reg)
            S_SRCH: begin
                e_rd_addr = j_reg[ADDR_W-1:0];
            end
            S_RDA: begin
                e_rd_addr = lo_idx[ADDR_W-1:0];
                f_rd_addr = j_reg[ADDR_W-1:0];
            end
            S_RDB: begin
                f_rd_addr = lo_idx[ADDR_W-1:0];
            end
            default: begin
                e_rd_addr = '0;
                f_rd_addr = '0;
            end
        endcase
    end

    assign tbl_wr_en = s_fire && (s_action == ACT_APPEND) && (count_reg < DEPTH_CNT);
    assign div_start = (state_reg == S_DIV);

    // Sequencer and datapath next values.
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        sp_next        = sp_reg;
        j_next         = j_reg;
        edge_seen_next = edge_seen_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        prev_edge_next = prev_edge_reg;
        mid_next       = mid_reg;
        width_mag_next = width_mag_reg;
        width_neg_next = width_neg_reg;
        e_hi_next      = e_hi_reg;
        e_lo_next      = e_lo_reg;
        f_hi_next      = f_hi_reg;
        f_lo_next      = f_lo_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        prod_next      = prod_reg;
        den_mag_next   = den_mag_reg;
        quo_neg_next   = quo_neg_reg;
        res_neg_next   = res_neg_reg;
        sat_next       = sat_reg;
        outside_next   = outside_reg;
        m_bin_next     = m_bin_reg;
        m_out_next     = m_out_reg;
        m_sat_next     = m_sat_reg;

        unique case (state_reg)
            // Take one request; only a next edge starts a bin computation.
            S_IDLE: begin
                if (s_fire) begin
                    unique case (s_action)
                        ACT_CLEAR: begin
                            count_next     = '0;
                            sp_next        = '0;
                            edge_seen_next = 1'b0;
                        end
                        ACT_APPEND: begin
                            if (count_reg < DEPTH_CNT) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_FIRST_EDGE: begin
                            prev_edge_next = s_energy_value;
                            edge_seen_next = 1'b1;
                            sp_next        = '0;
                        end
                        ACT_NEXT_EDGE: begin
                            prev_edge_next = s_energy_value;
                            if (!edge_seen_reg) begin
                                edge_seen_next = 1'b1;
                                sp_next        = '0;
                            end else begin
                                mid_next       = edge_sum[DATA_W:1];
                                width_neg_next = width_diff[DATA_W];
                                width_mag_next = width_abs[DATA_W-1:0];
                                j_next         = sp_reg;
                                sat_next       = 1'b0;
                                outside_next   = 1'b0;
                                state_next     = S_SRCH;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // Read the next candidate, or stop at the end of the table.
            S_SRCH: begin
                if (j_reg < count_reg) begin
                    state_next = S_CMP;
                end else begin
                    sp_next      = sp_back;
                    outside_next = 1'b1;
                    state_next   = S_OUT;
                end
            end
            // Compare the candidate energy against the midpoint.
            S_CMP: begin
                if (e_rd_data < mid_reg) begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = S_SRCH;
                end else begin
                    e_hi_next = e_rd_data;
                    sp_next   = sp_back;
                    if (j_reg == '0) begin
                        outside_next = 1'b1;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA: begin
                state_next = S_RDB;
            end
            S_RDB: begin
                e_lo_next  = e_rd_data;
                f_hi_next  = f_rd_data;
                state_next = S_RDC;
            end
            // Form magnitudes and the quotient sign; coinciding points stop here.
            S_RDC: begin
                f_lo_next    = f_rd_data;
                mul_a_next   = dflux_abs[DATA_W-1:0];
                mul_b_next   = num_abs[DATA_W-1:0];
                den_mag_next = den_abs[DATA_W-1:0];
                quo_neg_next = dflux_diff[DATA_W] ^ num_diff[DATA_W] ^ den_diff[DATA_W];
                if (den_diff == '0) begin
                    outside_next = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                prod_next  = mul_full;
                state_next = S_DIV;
            end
            S_DIV: begin
                state_next = S_DIVW;
            end
            // Build the clipped flux and set up the width product.
            S_DIVW: begin
                if (div_status.done) begin
                    sat_next     = flux_clip;
                    mul_a_next   = flux_abs[DATA_W-1:0];
                    mul_b_next   = width_mag_reg;
                    res_neg_next = flux_val[DATA_W-1] ^ width_neg_reg;
                    state_next   = S_MUL2;
                end
            end
            S_MUL2: begin
                prod_next  = mul_full;
                state_next = S_OUT;
            end
            // Load the output register once it is free.
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_out_next   = outside_reg;
                    m_bin_next   = outside_reg ? '0 : res_val;
                    m_sat_next   = !outside_reg && (sat_reg || res_clip);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sp_reg        <= '0;
            j_reg         <= '0;
            edge_seen_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            prev_edge_reg <= '0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sp_reg        <= sp_next;
            j_reg         <= j_next;
            edge_seen_reg <= edge_seen_next;
            m_valid_reg   <= m_valid_next;
            prev_edge_reg <= prev_edge_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mid_reg       <= mid_next;
        width_mag_reg <= width_mag_next;
        width_neg_reg <= width_neg_next;
        e_hi_reg      <= e_hi_next;
        e_lo_reg      <= e_lo_next;
        f_hi_reg      <= f_hi_next;
        f_lo_reg      <= f_lo_next;
        mul_a_reg     <= mul_a_next;
        mul_b_reg     <= mul_b_next;
        prod_reg      <= prod_next;
        den_mag_reg   <= den_mag_next;
        quo_neg_reg   <= quo_neg_next;
        res_neg_reg   <= res_neg_next;
        sat_reg       <= sat_next;
        outside_reg   <= outside_next;
        m_bin_reg     <= m_bin_next;
        m_out_reg     <= m_out_next;
        m_sat_reg     <= m_sat_next;
    end

    lir_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (tbl_wr_en),
        .wr_addr   (count_reg[ADDR_W-1:0]),
        .wr_energy (s_energy_value),
        .wr_flux   (s_flux_value),
        .e_rd_addr (e_rd_addr),
        .f_rd_addr (f_rd_addr),
        .e_rd_data (e_rd_data),
        .f_rd_data (f_rd_data)
    );

    lir_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_mag_reg),
        .quotient (div_quotient),
        .status   (div_status)
    );

    assign m_valid         = m_valid_reg;
    assign m_bin_value     = m_bin_reg;
    assign m_outside_table = m_out_reg;
    assign m_saturated     = m_sat_reg;

    // Checks on the sequencer and its state.
    `ASSERT_IMPL(a_outside_zero, aclk, aresetn, m_valid && m_outside_table, (m_bin_value == '0) && !m_saturated, "outside result carries a value or a clip flag")
    `ASSERT_ALWAYS(a_sp_bound, aclk, aresetn, sp_reg <= count_reg, "search pointer beyond the point count")
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT, "point count beyond the table depth")
    `ASSERT_IMPL(a_div_done_state, aclk, aresetn, div_status.done, state_reg == S_DIVW, "divider finished while the sequencer was not waiting")

endmodule

// File: tb/tb_linear_interp_rebinner.sv
// ----------------------------------------------------------------------------
// Linear interpolation rebinner testbench
// Loads point tables into the rebinner and sends grids of bin edges through
// it. Both sides idle and stall at random. A predictor inside the bench
// computes each bin value, and the monitor compares every returned result
// field by field with the oldest bin still owed.
// ----------------------------------------------------------------------------
module tb_linear_interp_rebinner;
    import lir_pkg::*;

    localparam int     TABLE_DEPTH  = 256;
    localparam int     TARGET_REQS  = 1250;
    localparam int     IDLE_PCT     = 20;
    localparam int     DRAIN_CYCLES = 600;
    localparam longint HALF_PERIOD  = 10;
    localparam longint RUN_LIMIT    = 64'd4_000_000 * 2 * HALF_PERIOD;
    localparam longint Q_MAX        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Q_MIN        = -64'sh0000_0000_8000_0000;
    localparam int     PRINT_CAP    = 100;

    // One request on the input channel.
    typedef struct {
        logic [1:0]        action;
        bit [DATA_W-1:0]   energy;
        bit [DATA_W-1:0]   flux;
    } rebin_req_t;

    // One bin result as the block should return it.
    typedef struct {
        bit [DATA_W-1:0] value;
        bit              outside;
        bit              sat;
    } bin_result_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [1:0]        s_action        = ACT_CLEAR;
    logic [DATA_W-1:0] s_energy_value  = '0;
    logic [DATA_W-1:0] s_flux_value    = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [DATA_W-1:0] m_bin_value;
    logic              m_outside_table;
    logic              m_saturated;

    // Requests waiting to be driven, and bins owed by the block.
    rebin_req_t  pending_reqs[$];
    bin_result_t bin_expect[$];

    // Predictor copy of the block state.
    bit [DATA_W-1:0] energy_tab[TABLE_DEPTH];
    bit [DATA_W-1:0] flux_tab[TABLE_DEPTH];
    int              point_count = 0;
    int              search_ptr  = 0;
    bit [DATA_W-1:0] last_edge   = '0;
    bit              edge_open   = 1'b0;

    int sent_count     = 0;
    int taken_count    = 0;
    int bins_checked   = 0;
    int mismatch_count = 0;
    int append_count   = 0;
    int bins_owed      = 0;
    int outside_count  = 0;
    int clip_count     = 0;

    linear_interp_rebinner #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_energy_value (s_energy_value),
        .s_flux_value   (s_flux_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_bin_value    (m_bin_value),
        .m_outside_table(m_outside_table),
        .m_saturated    (m_saturated)
    );

    // Free-running clock.
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    function automatic bit [63:0] magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Clip to the signed 32-bit range and flag the clip.
    function automatic longint clamp32(input longint v, inout bit hit);
        if (v > Q_MAX) begin
            hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            hit = 1'b1;
            return Q_MIN;
        end
        return v;
    endfunction

    // Update the table state for one request, and queue the bin it owes.
    function automatic void predict_request(input rebin_req_t r);
        bit [DATA_W:0]   edge_sum;
        bit [DATA_W-1:0] left_edge;
        bit [DATA_W-1:0] mid;
        longint          span, dflux, num, den, flux, binv;
        bit [63:0]       prod, quot;
        int              j;
        bit              neg, clip;
        bin_result_t     res;
        case (r.action)
            ACT_CLEAR: begin
                point_count = 0;
                search_ptr  = 0;
                edge_open   = 1'b0;
            end
            ACT_APPEND: begin
                append_count++;
                // A full table drops the point.
                if (point_count < TABLE_DEPTH) begin
                    energy_tab[point_count] = r.energy;
                    flux_tab[point_count]   = r.flux;
                    point_count++;
                end
            end
            default: begin
                if (r.action == ACT_FIRST_EDGE || !edge_open) begin
                    // Start of a grid; a next edge with no grid open counts as one.
                    last_edge  = r.energy;
                    edge_open  = 1'b1;
                    search_ptr = 0;
                end else begin
                    left_edge = last_edge;
                    last_edge = r.energy;
                    edge_sum  = {1'b0, left_edge} + {1'b0, r.energy};
                    mid       = edge_sum[DATA_W:1];
                    span      = {32'h0, r.energy} - {32'h0, left_edge};

                    // Walk forward to the first point at or above the midpoint.
                    j = search_ptr;
                    while (j < point_count && j < TABLE_DEPTH && energy_tab[j] < mid)
                        j++;
                    search_ptr = (j > 0) ? j - 1 : 0;

                    res.value   = '0;
                    res.outside = 1'b1;
                    res.sat     = 1'b0;
                    if (j != 0 && j < point_count) begin
                        den = {32'h0, energy_tab[j]} - {32'h0, energy_tab[j-1]};
                        if (den != 0) begin
                            // Interpolate between the bracketing points.
                            dflux = longint'($signed(flux_tab[j]))
                                  - longint'($signed(flux_tab[j-1]));
                            num   = {32'h0, mid} - {32'h0, energy_tab[j-1]};
                            prod  = magnitude(dflux) * magnitude(num);
                            quot  = prod / magnitude(den);
                            neg   = ((dflux < 0) != (num < 0)) != (den < 0);
                            clip  = 1'b0;
                            if (quot > 64'h2_0000_0000) begin
                                clip = 1'b1;
                                flux = neg ? Q_MIN : Q_MAX;
                            end else begin
                                flux = longint'($signed(flux_tab[j-1]))
                                     + (neg ? -longint'(quot) : longint'(quot));
                                flux = clamp32(flux, clip);
                            end
                            // Scale by the bin width, truncating toward zero.
                            binv        = (flux * span) / 65536;
                            binv        = clamp32(binv, clip);
                            res.value   = binv[31:0];
                            res.outside = 1'b0;
                            res.sat     = clip;
                        end
                    end
                    bins_owed++;
                    if (res.outside)
                        outside_count++;
                    if (res.sat)
                        clip_count++;
                    bin_expect.push_back(res);
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        // Keep the log readable when the block is badly broken.
        if (mismatch_count <= PRINT_CAP)
            $display("ERROR bin %0d: %s is %h, expected %h", bins_checked, what, got, want);
    endtask

    // Stimulus building.
    task automatic push_req(input logic [1:0] action, input bit [DATA_W-1:0] energy,
                            input bit [DATA_W-1:0] flux);
        rebin_req_t r;
        r.action = action;
        r.energy = energy;
        r.flux   = flux;
        pending_reqs.push_back(r);
    endtask

    function automatic bit [DATA_W-1:0] fit_energy(input longint v);
        if (v < 0)
            return '0;
        if (v > 64'hFFFF_FFFF)
            return 32'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic bit [DATA_W-1:0] rand_upto(input longint n);
        if (n <= 0)
            return '0;
        if (n >= 64'hFFFF_FFFF)
            return $urandom;
        return $urandom_range(0, n[31:0]);
    endfunction

    // Append n ascending points, a few of them with repeated energies.
    task automatic load_table(input int n, output bit [DATA_W-1:0] e_first,
                              output bit [DATA_W-1:0] e_last);
        longint          e, step_max;
        bit              wide;
        bit [DATA_W-1:0] fx;
        wide = ($urandom_range(0, 2) == 0);
        if (wide) begin
            e        = $urandom_range(0, 32'h8000_0000);
            step_max = (64'hFFFF_FFFF - e) / n;
        end else begin
            e        = $urandom_range(0, 32'h00FF_FFFF);
            step_max = $urandom_range(1, 32'h0004_0000);
        end
        if (step_max < 1)
            step_max = 1;
        e_first = fit_energy(e);
        for (int k = 0; k < n; k++) begin
            if (k != 0 && $urandom_range(0, 9) != 0)
                e = e + 1 + rand_upto(step_max - 1);
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            if ($urandom_range(0, 1) != 0)
                fx = $urandom;
            else
                fx = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            push_req(ACT_APPEND, e[31:0], fx);
        end
        e_last = fit_energy(e);
    endtask

    // A grid of m bins around the table range, mostly ascending.
    task automatic run_grid(input bit [DATA_W-1:0] e_first, input bit [DATA_W-1:0] e_last,
                            input int m, input bit with_first);
        longint lo_g, hi_g, e, margin, step_max, step;
        bit     down;
        lo_g = e_first;
        hi_g = e_last;
        if (hi_g < lo_g) begin
            e    = lo_g;
            lo_g = hi_g;
            hi_g = e;
        end
        margin   = (hi_g - lo_g) / 4 + 64'h1_0000;
        lo_g     = lo_g - margin;
        hi_g     = hi_g + margin;
        step_max = 2 * (hi_g - lo_g) / m;
        down     = ($urandom_range(0, 9) == 0);
        e        = down ? hi_g : lo_g;
        if (with_first)
            push_req(ACT_FIRST_EDGE, fit_energy(e), $urandom);
        for (int k = 0; k < m; k++) begin
            step = ($urandom_range(0, 19) == 0) ? 0 : rand_upto(step_max);
            e    = down ? e - step : e + step;
            push_req(ACT_NEXT_EDGE, fit_energy(e), $urandom);
        end
    endtask

    // Driver: presents requests at the falling edge and holds them until taken.
    always @(negedge aclk) begin
        rebin_req_t r;
        bit         quiet_tx, quiet_rx;
        quiet_tx = (sent_count >= 400 && sent_count < 700);
        quiet_rx = (bins_checked >= 200 && bins_checked < 400);
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (sent_count != taken_count) begin
            // The request on the port is still waiting for the block.
        end else if (pending_reqs.size() != 0 &&
                     (quiet_tx || $urandom_range(0, 99) >= IDLE_PCT)) begin
            r = pending_reqs.pop_front();
            s_valid        <= 1'b1;
            s_action       <= r.action;
            s_energy_value <= r.energy;
            s_flux_value   <= r.flux;
            sent_count++;
        end else begin
            s_valid        <= 1'b0;
            s_action       <= 2'($urandom_range(0, 3));
            s_energy_value <= $urandom;
            s_flux_value   <= $urandom;
        end
        m_ready <= quiet_rx || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: checks returned bins, then feeds taken requests to the predictor.
    always @(posedge aclk) begin
        bin_result_t want;
        rebin_req_t  r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bin_expect.size() == 0) begin
                    report_mismatch("result with nothing owed", m_bin_value, '0);
                end else begin
                    want = bin_expect.pop_front();
                    if (m_bin_value !== want.value)
                        report_mismatch("bin_value", m_bin_value, want.value);
                    if (m_outside_table !== want.outside)
                        report_mismatch("outside_table", DATA_W'(m_outside_table),
                                        DATA_W'(want.outside));
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", DATA_W'(m_saturated),
                                        DATA_W'(want.sat));
                end
                bins_checked++;
            end
            if (s_valid && s_ready) begin
                r.action = s_action;
                r.energy = s_energy_value;
                r.flux   = s_flux_value;
                predict_request(r);
                taken_count++;
            end
        end
    end

    // Main sequence: build the stimulus, release reset, drain and judge.
    initial begin
        bit [DATA_W-1:0] ef, el;
        int              pick, n;
        bit              full_done;
        ef        = 32'h0001_0000;
        el        = 32'h0010_0000;
        full_done = 1'b0;

        // Directed requests: edge before any grid, empty table, extreme fluxes,
        // a pair of equal energies, edges at the ends of the range, zero width,
        // descending edges, midpoints below, at and beyond the table ends.
        push_req(ACT_NEXT_EDGE,  32'h0000_1000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0000_3000, 32'h0000_0000);
        push_req(ACT_CLEAR,      32'h0000_0000, 32'h0000_0000);
        push_req(ACT_APPEND,     32'h0001_0000, 32'h7FFF_FFFF);
        push_req(ACT_APPEND,     32'h0002_0000, 32'h8000_0000);
        push_req(ACT_APPEND,     32'h0002_0000, 32'h0001_0000);
        push_req(ACT_APPEND,     32'h0100_0000, 32'h0000_0000);
        push_req(ACT_APPEND,     32'hFFFF_0000, 32'hFFFF_FFFF);
        push_req(ACT_FIRST_EDGE, 32'h0000_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0000_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0003_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0003_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0001_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'hFFFF_FFFF, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'hFFFF_FFFF, 32'h0000_0000);
        push_req(ACT_FIRST_EDGE, 32'h0000_8000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0000_C000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0001_4000, 32'h0000_0000);
        push_req(ACT_CLEAR,      32'h0000_0000, 32'h0000_0000);
        push_req(ACT_NEXT_EDGE,  32'h0001_0000, 32'h0000_0000);

        // Random part: mostly clean table loads followed by grids.
        while (pending_reqs.size() < TARGET_REQS) begin
            pick = $urandom_range(0, 99);
            if (!full_done && (pick < 3 || pending_reqs.size() > 600)) begin
                // Fill the table, then try to append past its end.
                push_req(ACT_CLEAR, $urandom, $urandom);
                load_table(TABLE_DEPTH, ef, el);
                repeat ($urandom_range(1, 3))
                    push_req(ACT_APPEND, $urandom, $urandom);
                run_grid(ef, el, $urandom_range(8, 20), 1'b1);
                full_done = 1'b1;
            end else if (pick < 70) begin
                push_req(ACT_CLEAR, $urandom, $urandom);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                load_table(n, ef, el);
                repeat ($urandom_range(1, 3))
                    run_grid(ef, el, $urandom_range(1, 16), 1'b1);
            end else if (pick < 88) begin
                // Broken sequences.
                case ($urandom_range(0, 2))
                    0: begin
                        push_req(ACT_CLEAR, $urandom, $urandom);
                        repeat ($urandom_range(1, 3))
                            push_req(ACT_NEXT_EDGE, $urandom, $urandom);
                    end
                    1: begin
                        repeat ($urandom_range(1, 4))
                            push_req(ACT_APPEND, $urandom, $urandom);
                        run_grid(ef, el, $urandom_range(1, 8), 1'b1);
                    end
                    default: run_grid(ef, el, $urandom_range(1, 8), 1'b0);
                endcase
            end else begin
                // Noise: anything at all.
                repeat ($urandom_range(1, 8))
                    push_req(2'($urandom_range(0, 3)), $urandom, $urandom);
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (pending_reqs.size() != 0 || sent_count != taken_count || bin_expect.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests (%0d appends); checked %0d bins,", taken_count,
                 append_count, bins_checked);
        $display("%0d of them outside the table and %0d clipped.", outside_count, clip_count);
        if (mismatch_count == 0 && bin_expect.size() == 0 && bins_checked == bins_owed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #RUN_LIMIT;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lir_pkg.sv
rtl/lir_table.sv
rtl/lir_div.sv
rtl/linear_interp_rebinner.sv
tb/tb_linear_interp_rebinner.sv
